### rtl/core/utf8_display_width_macros.svh
// Assertion macros shared by the UTF-8 display width RTL.
`ifndef UTF8_DISPLAY_WIDTH_MACROS_SVH
`define UTF8_DISPLAY_WIDTH_MACROS_SVH

// Checks a condition in the same cycle as its trigger.
`define UTF8DW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition in the cycle after its trigger.
`define UTF8DW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/utf8dw_pkg.sv
// Types, constants and code point classification for the UTF-8 display width block.
package utf8dw_pkg;

  localparam int SUM_BITS = 32;
  localparam int OUT_BITS = 32;
  localparam int CP_BITS  = 21;

  localparam logic [CP_BITS-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_BITS-1:0] ZWJ_CP  = 21'h00200D;

  typedef logic [CP_BITS-1:0] cp_t;

  // One byte step as it leaves the input register.
  typedef struct packed {
    logic       fire;
    logic [7:0] data_byte;
    logic       present;
    logic       last;
  } step_t;

  // What the decoder hands to the accumulator for one step.
  typedef struct packed {
    logic       cp_valid;
    cp_t        cp;
    logic [1:0] flush_inc;
  } dec_t;

  // Total length of the sequence opened by a lead byte; 1 when the lead is invalid.
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd1;
    if (c[7:5] == 3'b110) len = 3'd2;
    else if (c[7:4] == 4'b1110) len = 3'd3;
    else if (c[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_mark(input cp_t cp);
    return (cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1DC0 && cp <= 21'h1DFF)
        || (cp >= 21'h20D0 && cp <= 21'h20FF) || (cp >= 21'hFE20 && cp <= 21'hFE2F);
  endfunction

  function automatic logic is_wide(input cp_t cp);
    return (cp >= 21'h1100 && cp <= 21'h115F)
        || (cp >= 21'h2E80 && cp <= 21'hA4CF && cp != 21'h303F)
        || (cp >= 21'hAC00 && cp <= 21'hD7A3)
        || (cp >= 21'hF900 && cp <= 21'hFAFF)
        || (cp >= 21'hFE10 && cp <= 21'hFE19)
        || (cp >= 21'hFF00 && cp <= 21'hFF60)
        || (cp >= 21'hFFE0 && cp <= 21'hFFE6)
        || (cp >= 21'h1F000 && cp <= 21'h1F9FF)
        || (cp >= 21'h20000 && cp <= 21'h3FFFD);
  endfunction

  // Columns taken by a code point that is not a joiner.
  function automatic logic [1:0] cp_weight(input cp_t cp);
    logic [1:0] w;
    if (cp == REPL_CP || is_mark(cp)) w = 2'd0;
    else if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) w = 2'd0;
    else if (is_wide(cp)) w = 2'd2;
    else w = 2'd1;
    return w;
  endfunction

endpackage

### rtl/core/utf8dw_decoder.sv
// Lenient UTF-8 decoder with the pending byte buffer and the end of string flush.
`include "utf8_display_width_macros.svh"

module utf8dw_decoder (
  input  logic                clk,
  input  logic                rst,
  input  utf8dw_pkg::step_t   step,
  output utf8dw_pkg::dec_t    dec
);

  logic [7:0] pend0, pend1, pend2;
  logic [1:0] pend_cnt;
  logic [1:0] pend_cnt_next;

  logic [7:0] b0, b1, b2;
  logic [2:0] need, n_new, n_flush;
  logic       complete;
  utf8dw_pkg::cp_t pair_cp;

  // A lone byte read again as a lead counts one column only if it is printable ASCII.
  function automatic logic single_weight(input logic [7:0] b);
    return (b[7] == 1'b0) && (b >= 8'h20) && (b != 8'h7F);
  endfunction

  always_comb begin
    b0 = (pend_cnt == 2'd0) ? step.data_byte : pend0;
    b1 = (step.present && pend_cnt == 2'd1) ? step.data_byte : pend1;
    b2 = (step.present && pend_cnt == 2'd2) ? step.data_byte : pend2;
    need     = utf8dw_pkg::seq_len(b0);
    n_new    = {1'b0, pend_cnt} + 3'd1;
    complete = step.present && (n_new >= need);
    if (complete) n_flush = 3'd0;
    else if (step.present) n_flush = n_new;
    else n_flush = {1'b0, pend_cnt};
  end

  // The held lead of a cut-off sequence gives a zero width replacement; the bytes
  // after it are read again as leads and can only form ASCII or a two-byte code point.
  always_comb begin
    dec.cp_valid = complete;
    unique case (need)
      3'd1: dec.cp = b0[7] ? utf8dw_pkg::REPL_CP : {13'd0, b0};
      3'd2: dec.cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3: dec.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4: dec.cp = {b0[2:0], b1[5:0], b2[5:0], step.data_byte[5:0]};
      default: dec.cp = utf8dw_pkg::REPL_CP;
    endcase
    pair_cp = {10'd0, b1[4:0], b2[5:0]};
    dec.flush_inc = 2'd0;
    if (n_flush == 3'd3 && b1[7:5] == 3'b110) begin
      dec.flush_inc = utf8dw_pkg::cp_weight(pair_cp);
    end else if (n_flush == 3'd3) begin
      dec.flush_inc = {1'b0, single_weight(b1)} + {1'b0, single_weight(b2)};
    end else if (n_flush == 3'd2) begin
      dec.flush_inc = {1'b0, single_weight(b1)};
    end
  end

  always_comb begin
    pend_cnt_next = pend_cnt;
    if (step.fire) begin
      if (step.last || complete) pend_cnt_next = 2'd0;
      else if (step.present) pend_cnt_next = n_new[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else begin
      pend_cnt <= pend_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && step.present && !complete && !step.last) begin
      unique case (pend_cnt)
        2'd0: pend0 <= step.data_byte;
        2'd1: pend1 <= step.data_byte;
        2'd2: pend2 <= step.data_byte;
        default: pend2 <= pend2;
      endcase
    end
  end

  `UTF8DW_ASSERT_NOW(a_pend_lead, pend_cnt != 2'd0, utf8dw_pkg::seq_len(pend0) != 3'd1, "no lead")

endmodule

### rtl/core/utf8dw_accum.sv
// Joiner handling, saturating column sum and the result register.
`include "utf8_display_width_macros.svh"

module utf8dw_accum (
  input  logic                            clk,
  input  logic                            rst,
  input  utf8dw_pkg::step_t               step,
  input  utf8dw_pkg::dec_t                dec,
  input  logic                            width_stall,
  output logic                            width_valid,
  output logic [utf8dw_pkg::OUT_BITS-1:0] col_width
);

  logic                              swallow, swallow_next;
  logic [utf8dw_pkg::SUM_BITS-1:0]   sum, sum_next, sum_sat;
  logic [utf8dw_pkg::SUM_BITS:0]     sum_ext;
  logic [1:0]                        inc;
  logic                              width_valid_next;

  // Only a transaction that leaves the input register may move the joiner flag.
  always_comb begin
    inc          = 2'd0;
    swallow_next = swallow;
    if (step.fire) begin
      if (dec.cp_valid) begin
        if (swallow) begin
          swallow_next = 1'b0;
        end else if (dec.cp == utf8dw_pkg::ZWJ_CP) begin
          swallow_next = 1'b1;
        end else begin
          inc = utf8dw_pkg::cp_weight(dec.cp);
        end
      end else if (step.last) begin
        inc = dec.flush_inc;
      end
      if (step.last) swallow_next = 1'b0;
    end
    sum_ext = {1'b0, sum} + (utf8dw_pkg::SUM_BITS + 1)'(inc);
    sum_sat = sum_ext[utf8dw_pkg::SUM_BITS] ? '1 : sum_ext[utf8dw_pkg::SUM_BITS-1:0];
  end

  always_comb begin
    sum_next         = sum;
    width_valid_next = width_valid && width_stall;
    if (step.fire) begin
      if (step.last) begin
        sum_next         = '0;
        width_valid_next = 1'b1;
      end else begin
        sum_next = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum         <= '0;
      swallow     <= 1'b0;
      width_valid <= 1'b0;
    end else begin
      sum         <= sum_next;
      swallow     <= swallow_next;
      width_valid <= width_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && step.last) begin
      col_width <= utf8dw_pkg::OUT_BITS'(sum_sat);
    end
  end

  `UTF8DW_ASSERT_NEXT(a_end_clears, step.fire && step.last, sum == '0 && !swallow, "not cleared")
  `UTF8DW_ASSERT_NEXT(a_sum_grows, step.fire && !step.last, sum >= $past(sum), "sum decreased")

endmodule

### rtl/core/utf8_display_width.sv
// Top level of the UTF-8 terminal column width block.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-----------------------------------
//   byte    | in        | byte_valid / byte_stall  | data_byte, byte_present, last
//   width   | out       | width_valid / width_stall| col_width
//
// One byte transaction is taken every cycle unless byte_stall is high; the width of a
// string is loaded into the result register at the edge that moves its last transaction
// out of the input register.
// The pace is set by the single decode and add stage between the two registers.
// byte_stall rises only while an end-of-string byte waits for the result register.
// rst is synchronous and clears the pending bytes, the joiner flag and the sum.
`include "utf8_display_width_macros.svh"

module utf8_display_width (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last,
  output logic        width_valid,
  input  logic        width_stall,
  output logic [31:0] col_width
);

  // Input register: holds one accepted byte transaction.
  logic       s1_valid, s1_valid_next;
  logic [7:0] s1_byte;
  logic       s1_present;
  logic       s1_last;

  logic              fire;
  logic              accept;
  utf8dw_pkg::step_t step;
  utf8dw_pkg::dec_t  dec;

  // A byte that ends no string never needs the result register, so it always
  // moves on; an end-of-string byte waits until the result slot is free or draining.
  assign fire       = s1_valid && (!s1_last || !width_valid || !width_stall);
  assign byte_stall = s1_valid && !fire;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) s1_valid_next = 1'b1;
    else if (fire) s1_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte    <= data_byte;
      s1_present <= byte_present;
      s1_last    <= last;
    end
  end

  always_comb begin
    step.fire      = fire;
    step.data_byte = s1_byte;
    step.present   = s1_present;
    step.last      = s1_last;
  end

  utf8dw_decoder u_decoder (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .dec  (dec)
  );

  utf8dw_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .dec         (dec),
    .width_stall (width_stall),
    .width_valid (width_valid),
    .col_width   (col_width)
  );

  `UTF8DW_ASSERT_NOW(a_stall_cause, byte_stall, s1_last && width_valid && width_stall, "bad stall")

endmodule
